// File: rtl/core/rmtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map text parser package
// Shared types, status codes and character helpers for the range map parser.
// ----------------------------------------------------------------------------
package rmtp_pkg;

	localparam int NUMBER_BITS_DEF = 64;
	localparam int RESULT_BITS     = 64;
	localparam int KEYWORD_LEN     = 5;

	// Keyword position codes beyond the five letter positions.
	localparam logic [2:0] KW_SKIP_SPACE = 3'd0;
	localparam logic [2:0] KW_SEPARATOR  = 3'd6;
	localparam logic [2:0] KW_ACCEPTED   = 3'd7;

	// Index of the last of the four fields in one record.
	localparam logic [1:0] FIELD_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_LEX   = 3'd1,
		ST_STRAY = 3'd2,
		ST_DONE  = 3'd3
	} status_t;

	typedef logic [RESULT_BITS-1:0] num_t;

	// Letter expected at keyword positions one through five.
	function automatic logic [7:0] keyword_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd1:    ch = 8'h67; // g
			3'd2:    ch = 8'h72; // r
			3'd3:    ch = 8'h6d; // m
			3'd4:    ch = 8'h61; // a
			3'd5:    ch = 8'h70; // p
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || is_alpha(c);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
	endfunction

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] d;
		if (is_digit(c)) begin
			d = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = 5'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = 5'(c - 8'h41 + 8'd10);
		end else begin
			d = 5'h10;
		end
		return d;
	endfunction

endpackage

// File: rtl/core/rmtp_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map parser input channel
// Valid/ready channel carrying one character or an end-of-input marker.
// ----------------------------------------------------------------------------
interface rmtp_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_req;

	modport source (output valid, output kind, output byte_req, input ready);
	modport sink   (input valid, input kind, input byte_req, output ready);
endinterface

// File: rtl/core/rmtp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map parser result channel
// Valid/ready channel carrying the status and an optional range record.
// ----------------------------------------------------------------------------
interface rmtp_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic               range_valid;
	logic [63:0]        source_db;
	logic signed [63:0] source_serial;
	logic signed [63:0] dest_db;
	logic signed [63:0] dest_serial;
	logic signed [63:0] range_count;

	modport source (output valid, output status, output range_valid, output source_db,
		output source_serial, output dest_db, output dest_serial, output range_count,
		input ready);
	modport sink (input valid, input status, input range_valid, input source_db,
		input source_serial, input dest_db, input dest_serial, input range_count,
		output ready);
endinterface

// File: rtl/core/range_map_text_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map text parser unit
// Streams characters of a "grmap { db { a-b: c +d ... } }" text and emits one
// result beat per input beat, carrying a status and any completed range.
// ----------------------------------------------------------------------------
// Each input beat is one character (kind 0) or an end-of-input marker (kind 1)
// and produces exactly one result beat, registered in the cycle after it is accepted. The
// unit sustains one beat per cycle: all decoding, the hex shift-add and the
// record arithmetic (one 64-bit add and one subtract) sit between the parser
// state registers and the result register, and a new beat is taken whenever
// the result register is empty or is being drained in the same cycle. The
// text must start with the case-insensitive keyword grmap, optionally after
// white space, followed by a character that is not a letter or digit. Numbers
// are hexadecimal and are NUMBER_BITS wide (wrapping); a number outside a
// block becomes the database id of the next block, and inside a block every
// four numbers form a record a-b: c +d or a-b: c -d. A completed record is
// reported on the beat of the character that ends its last number, with the
// destination serial a+d (or a-d) and the count b-a, both wrapping at 64 bits.
// Any nonzero status (lexical error, stray closing brace, done) is sticky:
// every later beat repeats it with no range until reset.
// ----------------------------------------------------------------------------
module range_map_text_parser_unit
	import rmtp_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rmtp_item_if.sink     item,
	rmtp_result_if.source result
);

	// Parser state.
	logic [2:0]             keyword_pos_q;
	logic                   in_number_q;
	logic [NUMBER_BITS-1:0] accum_q;
	logic                   negative_q;
	logic                   in_map_q;
	logic                   in_block_q;
	logic [1:0]             field_index_q;
	num_t                   block_db_q;
	num_t                   record_nums_q [3];
	status_t                final_status_q;

	// Next-state values.
	logic [2:0]             keyword_pos_d;
	logic                   in_number_d;
	logic [NUMBER_BITS-1:0] accum_d;
	logic                   negative_d;
	logic                   in_map_d;
	logic                   in_block_d;
	logic [1:0]             field_index_d;
	num_t                   block_db_d;
	num_t                   record_nums_d [3];

	// Result of the current beat.
	status_t status_d;
	logic    range_valid_d;
	num_t    source_db_d;
	num_t    source_serial_d;
	num_t    dest_db_d;
	num_t    dest_serial_d;
	num_t    range_count_d;

	// Result register.
	logic    result_valid_q;
	status_t status_q;
	logic    range_valid_q;
	num_t    source_db_q;
	num_t    source_serial_q;
	num_t    dest_db_q;
	num_t    dest_serial_q;
	num_t    range_count_q;

	logic item_fire;

	// The result register frees up in the same cycle it is drained.
	assign item.ready = !result_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;

	always_comb begin
		logic [7:0] c;
		logic [4:0] d;
		logic       more;
		logic [2:0] kp;
		num_t       v;

		c    = item.byte_req;
		d    = hex_value(c);
		more = 1'b1;
		kp   = keyword_pos_q;
		v    = '0;

		keyword_pos_d = keyword_pos_q;
		in_number_d   = in_number_q;
		accum_d       = accum_q;
		negative_d    = negative_q;
		in_map_d      = in_map_q;
		in_block_d    = in_block_q;
		field_index_d = field_index_q;
		block_db_d    = block_db_q;
		record_nums_d = record_nums_q;

		status_d        = ST_OK;
		range_valid_d   = 1'b0;
		source_db_d     = '0;
		source_serial_d = '0;
		dest_db_d       = '0;
		dest_serial_d   = '0;
		range_count_d   = '0;

		if (final_status_q != ST_OK) begin
			status_d = final_status_q;
		end else if (item.kind) begin
			// End of input leaves the state alone; it is only an error inside the map.
			status_d = in_map_q ? ST_LEX : ST_OK;
		end else if (c[7]) begin
			status_d = ST_LEX;
		end else begin
			if (in_number_q) begin
				if (is_alnum(c)) begin
					more = 1'b0;
					if (d[4]) begin
						status_d = ST_LEX;
					end else begin
						accum_d = {accum_q[NUMBER_BITS-5:0], d[3:0]};
					end
				end else begin
					// The number ends here; it may complete a record.
					v = RESULT_BITS'(accum_q);
					if (in_block_q) begin
						if (negative_q) begin
							v = '0 - v;
						end
						if (field_index_q == FIELD_LAST) begin
							range_valid_d   = 1'b1;
							source_db_d     = block_db_q;
							source_serial_d = record_nums_q[0];
							dest_db_d       = record_nums_q[2];
							dest_serial_d   = record_nums_q[0] + v;
							range_count_d   = record_nums_q[1] - record_nums_q[0];
							field_index_d   = '0;
						end else begin
							record_nums_d[field_index_q] = v;
							field_index_d = field_index_q + 2'd1;
						end
					end else begin
						block_db_d    = v;
						field_index_d = '0;
					end
					negative_d  = 1'b0;
					accum_d     = '0;
					in_number_d = 1'b0;
				end
			end

			if (more && keyword_pos_q != KW_ACCEPTED) begin
				if (keyword_pos_q == KW_SEPARATOR) begin
					if (is_alnum(c)) begin
						status_d = ST_LEX;
						more     = 1'b0;
					end else begin
						keyword_pos_d = KW_ACCEPTED;
					end
				end else begin
					more = 1'b0;
					if (!(keyword_pos_q == KW_SKIP_SPACE && is_space(c))) begin
						if (keyword_pos_q == KW_SKIP_SPACE) begin
							kp = 3'd1;
						end
						if (to_lower(c) == keyword_char(kp)) begin
							keyword_pos_d = kp + 3'd1;
						end else begin
							keyword_pos_d = kp;
							status_d      = ST_LEX;
						end
					end
				end
			end

			if (more && !is_space(c)) begin
				if (is_alnum(c)) begin
					if (d[4]) begin
						status_d = ST_LEX;
					end else begin
						accum_d     = NUMBER_BITS'(d[3:0]);
						in_number_d = 1'b1;
					end
				end else begin
					unique case (c)
						8'h3a: begin // ':'
							if (field_index_d != 2'd2) begin
								status_d = ST_LEX;
							end
						end
						8'h2d: begin // '-'
							if (field_index_d == FIELD_LAST) begin
								negative_d = 1'b1;
							end else if (field_index_d != 2'd1) begin
								status_d = ST_LEX;
							end
						end
						8'h2b: begin // '+'
							if (field_index_d != FIELD_LAST) begin
								status_d = ST_LEX;
							end
						end
						8'h7b: begin // '{'
							if (!in_map_q) begin
								in_map_d = 1'b1;
							end else if (in_block_q || field_index_d != 2'd0) begin
								status_d = ST_LEX;
							end else begin
								in_block_d = 1'b1;
							end
						end
						8'h7d: begin // '}'
							if (in_block_q) begin
								if (field_index_d != 2'd0) begin
									status_d = ST_LEX;
								end else begin
									in_block_d = 1'b0;
								end
							end else if (!in_map_q) begin
								status_d = ST_STRAY;
							end else begin
								in_map_d = 1'b0;
								status_d = ST_DONE;
							end
						end
						default: begin
							status_d = ST_LEX;
						end
					endcase
				end
			end
		end
	end

	// Parser state advances once per accepted beat. Once the status is sticky
	// the rest of the state no longer matters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_pos_q  <= KW_SKIP_SPACE;
			in_number_q    <= 1'b0;
			accum_q        <= '0;
			negative_q     <= 1'b0;
			in_map_q       <= 1'b0;
			in_block_q     <= 1'b0;
			field_index_q  <= '0;
			block_db_q     <= '0;
			record_nums_q  <= '{default: '0};
			final_status_q <= ST_OK;
		end else if (item_fire) begin
			keyword_pos_q  <= keyword_pos_d;
			in_number_q    <= in_number_d;
			accum_q        <= accum_d;
			negative_q     <= negative_d;
			in_map_q       <= in_map_d;
			in_block_q     <= in_block_d;
			field_index_q  <= field_index_d;
			block_db_q     <= block_db_d;
			record_nums_q  <= record_nums_d;
			final_status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_fire) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			status_q        <= status_d;
			range_valid_q   <= range_valid_d;
			source_db_q     <= source_db_d;
			source_serial_q <= source_serial_d;
			dest_db_q       <= dest_db_d;
			dest_serial_q   <= dest_serial_d;
			range_count_q   <= range_count_d;
		end
	end

	assign result.valid         = result_valid_q;
	assign result.status        = status_q;
	assign result.range_valid   = range_valid_q;
	assign result.source_db     = source_db_q;
	assign result.source_serial = $signed(source_serial_q);
	assign result.dest_db       = $signed(dest_db_q);
	assign result.dest_serial   = $signed(dest_serial_q);
	assign result.range_count   = $signed(range_count_q);

endmodule

// File: rtl/core/rmtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map parser port checker
// Watches the ports of the parser unit for status and flow rules.
// ----------------------------------------------------------------------------
module rmtp_checker
	import rmtp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  status,
	input logic        range_valid,
	input logic [63:0] source_db,
	input logic [63:0] dest_serial
);

	// First nonzero status delivered; every later beat must repeat it.
	logic [2:0] sticky_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= ST_OK;
		end else if (result_valid && result_ready && status != ST_OK && sticky_q == ST_OK) begin
			sticky_q <= status;
		end
	end

	// The unit never stalls its input while the result register is empty.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with an empty result register");

	// A record only comes with an ok or lexical error status.
	a_range_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && range_valid |-> (status == ST_OK || status == ST_LEX))
		else $error("range reported with a terminal status");

	// Without a record the range fields read zero.
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !range_valid |-> (source_db == '0 && dest_serial == '0))
		else $error("range fields nonzero without a record");

	// A terminal status repeats on every later beat, with no record.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sticky_q != ST_OK |-> (status == sticky_q && !range_valid))
		else $error("terminal status did not persist");

	// An accepted input beat always yields a result beat next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted beat produced no result");

endmodule

bind range_map_text_parser_unit rmtp_checker u_rmtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.status       (result.status),
	.range_valid  (result.range_valid),
	.source_db    (result.source_db),
	.dest_serial  (result.dest_serial)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map text parser testbench
// Streams keyword, brace and record text into the parser one character beat at
// a time, predicts every result beat in a scoreboard and compares each field.
// ----------------------------------------------------------------------------
// The parser's error and done statuses are sticky until reset, and reset is
// applied only once. So a run is shaped as one long text: a short directed
// opening (white space, end-of-input markers outside the map, a mixed-case
// keyword, a number before the map that becomes the first block's database
// id, one record), then several hundred beats of well-formed blocks holding
// random records, and finally one closing event picked at random: a proper
// close of the map, or one of the ways the text can go wrong. After that a
// tail of random bytes and end markers checks that the final status sticks.
// Both channels idle and stall at random, except in one calm stretch.
// ----------------------------------------------------------------------------
module testbench;
	import rmtp_pkg::*;

	localparam int  IDLE_PCT    = 23;
	localparam int  STIM_BEATS  = 860;
	localparam int  CALM_FROM   = 300;
	localparam int  CALM_TO     = 450;
	localparam int  DRAIN_AT    = 500;
	localparam int  TAIL_BEATS  = 30;
	localparam int  SETTLE      = 4;
	localparam int  STALL_LIMIT = 2000;

	localparam num_t NUM_MASK = {RESULT_BITS{1'b1}} >> (RESULT_BITS - NUMBER_BITS_DEF);

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_OPEN    = "{";
	localparam logic [7:0] CH_CLOSE   = "}";
	localparam logic [7:0] CH_COLON   = ":";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_G = "g";
	localparam logic [7:0] CH_LOWER_Z = "z";
	localparam logic [7:0] CH_DEL     = 8'h7f;

	// How the text ends once the random blocks are through.
	typedef enum int {
		FIN_DONE,
		FIN_END_MARK,
		FIN_NON_ASCII,
		FIN_NON_HEX,
		FIN_RECORD_ERR,
		FIN_PUNCT,
		FIN_STRAY
	} finale_t;

	typedef struct {
		status_t status;
		logic    range_valid;
		num_t    source_db;
		num_t    source_serial;
		num_t    dest_db;
		num_t    dest_serial;
		num_t    range_count;
	} range_beat_t;

	// Keeps its own copy of the parser state, works out the result beat of
	// every accepted input beat and checks the result beats in order.
	class range_map_scoreboard;
		range_beat_t expected_ranges[$];
		int          mismatches;
		int          beats_checked;

		logic [2:0]  kw_pos;
		bit          reading_num;
		num_t        acc;
		bit          neg;
		bit          map_open;
		bit          block_open;
		logic [1:0]  fld;
		num_t        db;
		num_t        rec[3];
		status_t     sticky;
		range_beat_t cur;
		string       keyword;

		function new();
			keyword       = "grmap";
			kw_pos        = KW_SKIP_SPACE;
			reading_num   = 1'b0;
			acc           = '0;
			neg           = 1'b0;
			map_open      = 1'b0;
			block_open    = 1'b0;
			fld           = '0;
			db            = '0;
			rec           = '{default: '0};
			sticky        = ST_OK;
			mismatches    = 0;
			beats_checked = 0;
		endfunction

		function bit blank(logic [7:0] c);
			return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
		endfunction

		function bit alnum(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		// 16 when the character is not a hex digit.
		function int hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - CH_ZERO);
			if (c >= "a" && c <= "f") return int'(c - CH_LOWER_A) + 10;
			if (c >= "A" && c <= "F") return int'(c - CH_UPPER_A) + 10;
			return 16;
		endfunction

		// Ends the number in acc: outside a block it names the database,
		// inside it is the next field, and the fourth field closes a record.
		function void close_number();
			num_t v;
			v = acc & NUM_MASK;
			if (block_open) begin
				if (neg) v = -v;
				if (fld == FIELD_LAST) begin
					cur.range_valid   = 1'b1;
					cur.source_db     = db;
					cur.source_serial = rec[0];
					cur.dest_db       = rec[2];
					cur.dest_serial   = rec[0] + v;
					cur.range_count   = rec[1] - rec[0];
					fld = '0;
				end else begin
					rec[fld] = v;
					fld++;
				end
			end else begin
				db  = v;
				fld = '0;
			end
			neg         = 1'b0;
			acc         = '0;
			reading_num = 1'b0;
		endfunction

		function status_t parse_char(logic [7:0] c);
			int d;
			logic [7:0] low;
			if (c[7]) return ST_LEX;
			if (reading_num) begin
				if (alnum(c)) begin
					d = hex_digit(c);
					if (d > 15) return ST_LEX;
					acc = ((acc << 4) + num_t'(d)) & NUM_MASK;
					return ST_OK;
				end
				close_number();
			end
			if (kw_pos != KW_ACCEPTED) begin
				if (kw_pos == KW_SEPARATOR) begin
					if (alnum(c)) return ST_LEX;
					kw_pos = KW_ACCEPTED;
				end else begin
					if (kw_pos == KW_SKIP_SPACE) begin
						if (blank(c)) return ST_OK;
						kw_pos = 3'd1;
					end
					low = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
					if (low == keyword[int'(kw_pos) - 1]) begin
						kw_pos++;
						return ST_OK;
					end
					return ST_LEX;
				end
			end
			if (blank(c)) return ST_OK;
			if (alnum(c)) begin
				d = hex_digit(c);
				if (d > 15) return ST_LEX;
				acc         = num_t'(d);
				reading_num = 1'b1;
				return ST_OK;
			end
			case (c)
				CH_COLON: return (fld == 2'd2) ? ST_OK : ST_LEX;
				CH_MINUS: begin
					if (fld == 2'd1) return ST_OK;
					if (fld == FIELD_LAST) begin
						neg = 1'b1;
						return ST_OK;
					end
					return ST_LEX;
				end
				CH_PLUS: return (fld == FIELD_LAST) ? ST_OK : ST_LEX;
				CH_OPEN: begin
					if (!map_open) begin
						map_open = 1'b1;
						return ST_OK;
					end
					if (block_open || fld != 2'd0) return ST_LEX;
					block_open = 1'b1;
					return ST_OK;
				end
				CH_CLOSE: begin
					if (block_open) begin
						if (fld != 2'd0) return ST_LEX;
						block_open = 1'b0;
						return ST_OK;
					end
					if (!map_open) return ST_STRAY;
					map_open = 1'b0;
					return ST_DONE;
				end
				default: return ST_LEX;
			endcase
		endfunction

		// Called for every accepted input beat.
		function void note_item(logic kind, logic [7:0] c);
			status_t st;
			cur = '{status: ST_OK, range_valid: 1'b0, default: '0};
			if (sticky != ST_OK) begin
				cur.status = sticky;
			end else begin
				if (kind == KIND_END) st = map_open ? ST_LEX : ST_OK;
				else st = parse_char(c);
				sticky     = st;
				cur.status = st;
			end
			expected_ranges.push_back(cur);
		endfunction

		function int pending();
			return expected_ranges.size();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 50) $display("MISMATCH %s", msg);
		endtask

		task compare(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s: got %h, expected %h", beats_checked, name,
					got, want));
		endtask

		// Called for every accepted result beat.
		task check_result(range_beat_t got);
			range_beat_t want;
			beats_checked++;
			if (expected_ranges.size() == 0) begin
				report($sformatf("result beat %0d arrived with nothing expected",
					beats_checked));
				return;
			end
			want = expected_ranges.pop_front();
			compare("status", 64'(got.status), 64'(want.status));
			compare("range_valid", 64'(got.range_valid), 64'(want.range_valid));
			compare("source_db", got.source_db, want.source_db);
			compare("source_serial", got.source_serial, want.source_serial);
			compare("dest_db", got.dest_db, want.dest_db);
			compare("dest_serial", got.dest_serial, want.dest_serial);
			compare("range_count", got.range_count, want.range_count);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rmtp_item_if   item_bus ();
	rmtp_result_if result_bus ();

	range_map_text_parser_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	always #5 clk = ~clk;

	range_map_scoreboard ranges;
	int                  beats_sent = 0;
	int                  idle_pct   = IDLE_PCT;

	// Handshakes are sampled at the falling edge, where every signal has
	// settled; the beat then moves at the rising edge that follows.
	task automatic send_beat(input logic kind, input logic [7:0] c);
		bit fire;
		while ($urandom_range(0, 99) < idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.kind     <= kind;
		item_bus.byte_req <= c;
		fire = 1'b0;
		while (!fire) begin
			@(negedge clk);
			fire = item_bus.ready;
			@(posedge clk);
		end
		ranges.note_item(kind, c);
		beats_sent++;
	endtask

	task automatic send_char(input logic [7:0] c);
		send_beat(KIND_CHAR, c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// Lowers valid and holds off until every expected result beat is back.
	// Valid is always held low across a rising edge, so it is never lowered and raised in one step.
	task automatic wait_for_results();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (ranges.pending() != 0);
	endtask

	// White space: mostly plain spaces, sometimes tab through carriage return.
	task automatic send_gap(input int least);
		int n;
		n = least + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
		repeat (n) send_char(($urandom_range(0, 2) != 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
	endtask

	// Hex number of mixed case. Most are short; some run past sixteen digits
	// so the accumulator wraps, and a few are all ones or all zeros.
	task automatic send_number();
		int len;
		int r;
		int d;
		logic [7:0] c;
		r = $urandom_range(0, 19);
		if (r < 10) len = $urandom_range(1, 6);
		else if (r < 16) len = $urandom_range(7, 16);
		else if (r < 18) len = $urandom_range(17, 20);
		else len = 16;
		for (int i = 0; i < len; i++) begin
			if (r == 18) d = 15;
			else if (r == 19) d = 0;
			else d = $urandom_range(0, 15);
			if (d < 10) c = CH_ZERO + 8'(d);
			else c = (($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
			send_char(c);
		end
	endtask

	// One record a-b: c +d. The dash and colon are sometimes left out (white
	// space then separates the numbers), and the offset may carry no sign, a
	// plus, a minus, a doubled minus or a plus followed by a minus. A tight
	// record ends right on its last digit so the caller's brace completes it.
	task automatic send_record(input bit tight);
		int s;
		send_number();
		if ($urandom_range(0, 7) != 0) begin
			send_gap(0);
			send_char(CH_MINUS);
			send_gap(0);
		end else begin
			send_gap(1);
		end
		send_number();
		if ($urandom_range(0, 7) != 0) begin
			send_gap(0);
			send_char(CH_COLON);
			send_gap(0);
		end else begin
			send_gap(1);
		end
		send_number();
		s = $urandom_range(0, 4);
		send_gap((s == 0) ? 1 : 0);
		case (s)
			1: send_char(CH_PLUS);
			2: send_char(CH_MINUS);
			3: begin
				send_char(CH_MINUS);
				send_gap(0);
				send_char(CH_MINUS);
			end
			4: begin
				send_char(CH_PLUS);
				send_char(CH_MINUS);
			end
			default: ;
		endcase
		if (s != 0) send_gap(0);
		send_number();
		if (!tight) send_gap(1);
	endtask

	// Database id (now and then left out, so the previous one carries over)
	// followed by the opening brace of a block.
	task automatic open_block();
		if ($urandom_range(0, 9) != 0) begin
			send_number();
			send_gap(0);
		end
		send_char(CH_OPEN);
		send_gap(0);
	endtask

	task automatic send_block(input int max_recs);
		int nrec;
		bit tight;
		open_block();
		nrec  = $urandom_range(0, max_recs);
		tight = $urandom_range(0, 1);
		for (int i = 0; i < nrec; i++) send_record(tight && i == nrec - 1);
		send_char(CH_CLOSE);
		send_gap(0);
	endtask

	// The sink stalls at the same rate the source idles.
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(negedge clk) begin : result_monitor
		range_beat_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.status        = status_t'(result_bus.status);
			got.range_valid   = result_bus.range_valid;
			got.source_db     = result_bus.source_db;
			got.source_serial = result_bus.source_serial;
			got.dest_db       = result_bus.dest_db;
			got.dest_serial   = result_bus.dest_serial;
			got.range_count   = result_bus.range_count;
			ranges.check_result(got);
		end
	end

	// Ends the run once no beat has moved on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		finale_t    finale;
		bit         drained_mid;
		int         r;
		logic [7:0] c;
		string      bad_punct;
		string      early_punct;

		ranges            = new();
		arst_n            = 1'b0;
		item_bus.valid    = 1'b0;
		item_bus.kind     = KIND_CHAR;
		item_bus.byte_req = 8'h00;
		drained_mid       = 1'b0;
		// Characters that are illegal right after a finished record.
		bad_punct         = "!#$%&*,./;<=>?@[]^_|~:{-";
		// Characters that are illegal between the first and second number.
		early_punct       = "+:{}";

		// The closing event is chosen up front: a stray closing brace is only
		// possible before the map opens, so that run skips the map entirely.
		r = $urandom_range(0, 12);
		if (r < 3) finale = FIN_DONE;
		else if (r < 5) finale = FIN_END_MARK;
		else if (r < 6) finale = FIN_NON_ASCII;
		else if (r < 8) finale = FIN_NON_HEX;
		else if (r < 10) finale = FIN_RECORD_ERR;
		else if (r < 12) finale = FIN_PUNCT;
		else finale = FIN_STRAY;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. End markers outside the map change nothing, even
		// in the middle of a number, so "1", end, "2" still reads as 0x12.
		// That number sits before the map and becomes the first block's id.
		send_text(" \v");
		send_beat(KIND_END, 8'h00);
		send_text("GrMaP\t1");
		send_beat(KIND_END, 8'h00);
		send_text("2 ");

		if (finale == FIN_STRAY) begin
			send_char(CH_CLOSE);
		end else begin
			// First block, whose record starts before any sign was seen and
			// is completed by the closing brace itself.
			send_text("{{0-1:2 -3}");
			wait_for_results();

			while (beats_sent < STIM_BEATS) begin
				idle_pct = (beats_sent >= CALM_FROM && beats_sent < CALM_TO) ? 0 : IDLE_PCT;
				if (!drained_mid && beats_sent >= DRAIN_AT) begin
					wait_for_results();
					drained_mid = 1'b1;
				end
				send_block(5);
			end
			idle_pct = IDLE_PCT;

			case (finale)
				FIN_DONE: send_char(CH_CLOSE);
				FIN_END_MARK: begin
					open_block();
					if ($urandom_range(0, 1) != 0) send_number();
					send_beat(KIND_END, 8'($urandom_range(0, 255)));
				end
				FIN_NON_ASCII: begin
					open_block();
					if ($urandom_range(0, 1) != 0) send_number();
					send_char(8'($urandom_range(128, 255)));
				end
				FIN_NON_HEX: begin
					open_block();
					send_number();
					c = 8'($urandom_range(CH_LOWER_G, CH_LOWER_Z));
					if ($urandom_range(0, 1) != 0) c = c - 8'h20;
					send_char(c);
				end
				FIN_RECORD_ERR: begin
					// The illegal character also ends the record, so its beat
					// carries the range together with the lexical error.
					open_block();
					send_record(1'b1);
					if ($urandom_range(0, 3) == 0)
						c = ($urandom_range(0, 1) != 0) ? CH_DEL : 8'($urandom_range(14, 31));
					else
						c = bad_punct[$urandom_range(0, bad_punct.len() - 1)];
					send_char(c);
				end
				default: begin
					open_block();
					send_number();
					send_gap(0);
					send_char(early_punct[$urandom_range(0, early_punct.len() - 1)]);
				end
			endcase
		end

		// Whatever the final status was, it has to hold from here on.
		repeat (TAIL_BEATS)
			send_beat(($urandom_range(0, 3) == 0) ? KIND_END : KIND_CHAR,
				8'($urandom_range(0, 255)));

		wait_for_results();
		repeat (SETTLE) @(posedge clk);

		if (ranges.mismatches == 0 && ranges.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
